@@ rtl/ufc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared constants and types of the upwind face coefficient pipeline.
// ----------------------------------------------------------------------------
package ufc_pkg;

    // Default number of fraction bits of the fixed point format.
    localparam int UFC_FRAC_BITS = 16;

    // Width of every data field.
    localparam int DATA_W = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_FLOOR    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [DATA_W-1:0] FLUX_THRESHOLD_RST = 32'd65;
    localparam logic [DATA_W-1:0] SLOPE_FLOOR_RST    = 32'd7;

    // Which mean forms the face value.
    typedef enum logic [1:0] {
        SEL_HARMONIC,
        SEL_ARITH,
        SEL_BLEND
    } t_mean_sel;

    // Face fields that travel alongside the square root units.
    typedef struct packed {
        logic [DATA_W-1:0] flux;
        logic              normal_out;
        logic              second;
        logic [DATA_W-1:0] coef_first;
        logic [DATA_W-1:0] coef_second;
        logic [DATA_W-1:0] coef_prev;
        logic [DATA_W-1:0] rough_first;
        logic [DATA_W-1:0] dist_first;
        logic [DATA_W-1:0] dist_second;
    } t_face;

    // Control that travels with the harmonic mean divider.
    typedef struct packed {
        t_mean_sel         sel;
        logic              hm_keep;
        logic [DATA_W-1:0] abs_flux;
    } t_mean_side;

    // Control that travels with the denominator divider.
    typedef struct packed {
        logic              second;
        logic [DATA_W-1:0] denom_first;
    } t_denom_side;

    // Control that travels with the blend divider.
    typedef struct packed {
        t_mean_sel         sel;
        logic              err;
        logic [DATA_W-1:0] hm;
        logic [DATA_W-1:0] am;
        logic [DATA_W-1:0] denom;
    } t_blend_side;

endpackage
`default_nettype wire

@@ rtl/upwind_face_coefficient.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// upwind_face_coefficient
// Upwind face coefficient of one mesh face per clock, unsigned fixed point.
// ----------------------------------------------------------------------------
// A face is taken at every clock edge where start is high; busy is always low
// because the datapath is a free-running pipeline that accepts one face per
// cycle without gaps. Each face produces exactly one result, shown for one
// cycle with o_strobe high, in the order the faces went in. The receiver
// cannot hold results off, and none is needed. The path runs through the
// bit-serial stages of the square root units, followed by three chained
// steps of 32-bit quotient dividers (the two means together with the
// denominator mean, then the blend ratio, then the final normalization),
// each divider 33 stages deep.
// The configuration registers are read directly by the pipeline, so they
// should be written only while no face is in flight.
// ----------------------------------------------------------------------------
module upwind_face_coefficient #(
    parameter int FRAC_BITS = ufc_pkg::UFC_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel.
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             i_face_flux,
    input  logic                           i_normal_points_out,
    input  logic                           i_has_second_cell,
    input  logic [31:0]                    i_coef_first,
    input  logic [31:0]                    i_coef_second,
    input  logic [31:0]                    i_face_coef_prev,
    input  logic [31:0]                    i_rough_first,
    input  logic [31:0]                    i_rough_second,
    input  logic signed [31:0]             i_slope_first,
    input  logic signed [31:0]             i_slope_second,
    input  logic [31:0]                    i_dist_first,
    input  logic [31:0]                    i_dist_second,
    // Result channel.
    output logic                           o_strobe,
    output logic [31:0]                    o_face_coef,
    output logic                           o_divide_error,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [ufc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_wdata
);
    import ufc_pkg::*;

    localparam int W      = DATA_W;
    localparam int SQ_W   = W + FRAC_BITS;        // shifted slope
    localparam int RT_W   = (SQ_W + 1) / 2;       // square root
    localparam int P_W    = 2 * W;                // 32 x 32 product
    localparam int PR_W   = W + RT_W;             // roughness times root
    localparam int MID_W  = 2 * W + 1;            // weighted sums
    localparam int WIDE_W = 3 * W + 1;            // harmonic numerators

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [W-1:0] r_flux_threshold;
    logic [W-1:0] r_slope_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flux_threshold <= FLUX_THRESHOLD_RST;
            r_slope_floor    <= SLOPE_FLOOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLUX_THRESHOLD: r_flux_threshold <= i_cfg_wdata;
                CFG_SLOPE_FLOOR:    r_slope_floor    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so every start is a transfer.
    assign busy = 1'b0;

    // A negative slope, or one below the floor, is replaced by the floor.
    function automatic logic [W-1:0] eff_slope(input logic [W-1:0] s,
                                               input logic [W-1:0] fl);
        return (!s[W-1] && (s > fl)) ? s : fl;
    endfunction

    // Shift right by the fraction bits and saturate to 32 bits.
    function automatic logic [W-1:0] sat_shift(input logic [P_W-1:0] x);
        logic [P_W-1:0] sh;
        sh = x >> FRAC_BITS;
        return (|sh[P_W-1:W]) ? '1 : sh[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Square roots of both effective slopes, shifted up by the fraction
    // bits. The remaining face fields ride along in the sideband.
    // ------------------------------------------------------------------
    logic              w_accept;
    t_face             w_face_in;
    logic [SQ_W-1:0]   w_x_first;
    logic [SQ_W-1:0]   w_x_second;
    logic              w_sqf_valid;
    logic              w_sqs_valid;
    logic [RT_W-1:0]   w_root_first;
    logic [RT_W-1:0]   w_root_second;
    t_face             w_sq_face;
    logic [W-1:0]      w_sq_rough_second;

    assign w_accept   = start && !busy;
    assign w_x_first  = {eff_slope(i_slope_first, r_slope_floor), {FRAC_BITS{1'b0}}};
    assign w_x_second = {eff_slope(i_slope_second, r_slope_floor), {FRAC_BITS{1'b0}}};

    always_comb begin
        w_face_in.flux        = i_face_flux;
        w_face_in.normal_out  = i_normal_points_out;
        w_face_in.second      = i_has_second_cell;
        w_face_in.coef_first  = i_coef_first;
        w_face_in.coef_second = i_coef_second;
        w_face_in.coef_prev   = i_face_coef_prev;
        w_face_in.rough_first = i_rough_first;
        w_face_in.dist_first  = i_dist_first;
        w_face_in.dist_second = i_dist_second;
    end

    ufc_sqrt_pipe #(
        .X_W    (SQ_W),
        .SIDE_W ($bits(t_face))
    ) u_sqrt_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_x     (w_x_first),
        .i_side  (w_face_in),
        .o_valid (w_sqf_valid),
        .o_root  (w_root_first),
        .o_side  (w_sq_face)
    );

    ufc_sqrt_pipe #(
        .X_W    (SQ_W),
        .SIDE_W (W)
    ) u_sqrt_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_x     (w_x_second),
        .i_side  (i_rough_second),
        .o_valid (w_sqs_valid),
        .o_root  (w_root_second),
        .o_side  (w_sq_rough_second)
    );

    // ------------------------------------------------------------------
    // Stage 1: upwind decision, flux magnitude, cell denominator products.
    // The first cell is upwind when the flux leaves it along the normal;
    // a zero flux leaves the first cell downwind.
    // ------------------------------------------------------------------
    logic            r_s1_valid;
    logic [PR_W-1:0] r_s1_prod_f;
    logic [PR_W-1:0] r_s1_prod_s;
    logic            r_s1_first_up;
    logic [W-1:0]    r_s1_abs;
    t_face           r_s1_face;

    always_ff @(posedge i_clk) begin
        r_s1_prod_f   <= PR_W'(w_sq_face.rough_first) * PR_W'(w_root_first);
        r_s1_prod_s   <= PR_W'(w_sq_rough_second) * PR_W'(w_root_second);
        r_s1_first_up <= (w_sq_face.flux != '0) &&
                         (w_sq_face.flux[W-1] != w_sq_face.normal_out);
        r_s1_abs      <= w_sq_face.flux[W-1] ? (~w_sq_face.flux + 1'b1) : w_sq_face.flux;
        r_s1_face     <= w_sq_face;
    end

    // ------------------------------------------------------------------
    // Stage 2: saturate the cell denominators and order everything as
    // upwind (index 0) and downwind (index 1). A boundary face uses only
    // the first cell; on inflow its upwind coefficient is the prior value.
    // ------------------------------------------------------------------
    logic         r_s2_valid;
    logic [W-1:0] r_s2_d0, r_s2_d1, r_s2_w0, r_s2_w1, r_s2_ca, r_s2_cb, r_s2_abs;
    logic         r_s2_second;
    logic [W-1:0] n_s2_d0, n_s2_d1, n_s2_w0, n_s2_w1, n_s2_ca, n_s2_cb;
    logic [W-1:0] w_dfst, w_dsnd;

    assign w_dfst = sat_shift(P_W'(r_s1_prod_f));
    assign w_dsnd = sat_shift(P_W'(r_s1_prod_s));

    always_comb begin
        if (!r_s1_face.second) begin
            n_s2_d0 = w_dfst;
            n_s2_d1 = w_dfst;
            n_s2_w0 = r_s1_face.dist_first;
            n_s2_w1 = r_s1_face.dist_first;
            n_s2_ca = r_s1_first_up ? r_s1_face.coef_first : r_s1_face.coef_prev;
            n_s2_cb = r_s1_face.coef_first;
        end else if (r_s1_first_up) begin
            n_s2_d0 = w_dfst;
            n_s2_d1 = w_dsnd;
            n_s2_w0 = r_s1_face.dist_first;
            n_s2_w1 = r_s1_face.dist_second;
            n_s2_ca = r_s1_face.coef_first;
            n_s2_cb = r_s1_face.coef_second;
        end else begin
            n_s2_d0 = w_dsnd;
            n_s2_d1 = w_dfst;
            n_s2_w0 = r_s1_face.dist_second;
            n_s2_w1 = r_s1_face.dist_first;
            n_s2_ca = r_s1_face.coef_second;
            n_s2_cb = r_s1_face.coef_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_d0     <= n_s2_d0;
        r_s2_d1     <= n_s2_d1;
        r_s2_w0     <= n_s2_w0;
        r_s2_w1     <= n_s2_w1;
        r_s2_ca     <= n_s2_ca;
        r_s2_cb     <= n_s2_cb;
        r_s2_abs    <= r_s1_abs;
        r_s2_second <= r_s1_face.second;
    end

    // ------------------------------------------------------------------
    // Stage 3: coefficient scaling products and the products of the
    // combined denominator's harmonic mean.
    // ------------------------------------------------------------------
    logic           r_s3_valid;
    logic [P_W-1:0] r_s3_pa, r_s3_pb, r_s3_pd, r_s3_qd, r_s3_qe;
    logic [W-1:0]   r_s3_w0, r_s3_w1, r_s3_d0, r_s3_abs;
    logic           r_s3_second;

    always_ff @(posedge i_clk) begin
        r_s3_pa     <= P_W'(r_s2_ca) * P_W'(r_s2_d0);
        r_s3_pb     <= P_W'(r_s2_cb) * P_W'(r_s2_d1);
        r_s3_pd     <= P_W'(r_s2_d0) * P_W'(r_s2_d1);
        r_s3_qd     <= P_W'(r_s2_w0) * P_W'(r_s2_d1);
        r_s3_qe     <= P_W'(r_s2_w1) * P_W'(r_s2_d0);
        r_s3_w0     <= r_s2_w0;
        r_s3_w1     <= r_s2_w1;
        r_s3_d0     <= r_s2_d0;
        r_s3_abs    <= r_s2_abs;
        r_s3_second <= r_s2_second;
    end

    // ------------------------------------------------------------------
    // Stage 4: scaled coefficients, weight sum, denominator divisor.
    // ------------------------------------------------------------------
    logic             r_s4_valid;
    logic [W-1:0]     r_s4_c0, r_s4_c1, r_s4_w0, r_s4_w1, r_s4_d0, r_s4_abs;
    logic [W:0]       r_s4_ws;
    logic [MID_W-1:0] r_s4_dend;
    logic [P_W-1:0]   r_s4_pd;
    logic             r_s4_second;

    always_ff @(posedge i_clk) begin
        r_s4_c0     <= sat_shift(r_s3_pa);
        r_s4_c1     <= sat_shift(r_s3_pb);
        r_s4_ws     <= {1'b0, r_s3_w0} + {1'b0, r_s3_w1};
        r_s4_dend   <= MID_W'(r_s3_qd) + MID_W'(r_s3_qe);
        r_s4_pd     <= r_s3_pd;
        r_s4_w0     <= r_s3_w0;
        r_s4_w1     <= r_s3_w1;
        r_s4_d0     <= r_s3_d0;
        r_s4_abs    <= r_s3_abs;
        r_s4_second <= r_s3_second;
    end

    // ------------------------------------------------------------------
    // Stage 5: products of both coefficient means, and the denominator
    // numerator split into two partial products.
    // ------------------------------------------------------------------
    logic             r_s5_valid;
    logic [P_W-1:0]   r_s5_pc, r_s5_hc, r_s5_hd, r_s5_ac, r_s5_ad;
    logic [MID_W-1:0] r_s5_nd_lo, r_s5_nd_hi, r_s5_dend;
    logic [W-1:0]     r_s5_c0, r_s5_c1, r_s5_d0, r_s5_abs;
    logic [W:0]       r_s5_ws;
    logic             r_s5_second;

    always_ff @(posedge i_clk) begin
        r_s5_pc     <= P_W'(r_s4_c0) * P_W'(r_s4_c1);
        r_s5_hc     <= P_W'(r_s4_w0) * P_W'(r_s4_c1);
        r_s5_hd     <= P_W'(r_s4_w1) * P_W'(r_s4_c0);
        r_s5_ac     <= P_W'(r_s4_w0) * P_W'(r_s4_c0);
        r_s5_ad     <= P_W'(r_s4_w1) * P_W'(r_s4_c1);
        r_s5_nd_lo  <= MID_W'(r_s4_pd[W-1:0]) * MID_W'(r_s4_ws);
        r_s5_nd_hi  <= MID_W'(r_s4_pd[P_W-1:W]) * MID_W'(r_s4_ws);
        r_s5_dend   <= r_s4_dend;
        r_s5_c0     <= r_s4_c0;
        r_s5_c1     <= r_s4_c1;
        r_s5_d0     <= r_s4_d0;
        r_s5_abs    <= r_s4_abs;
        r_s5_ws     <= r_s4_ws;
        r_s5_second <= r_s4_second;
    end

    // ------------------------------------------------------------------
    // Stage 6: sums of the means, coefficient numerator partial products.
    // ------------------------------------------------------------------
    logic              r_s6_valid;
    logic [WIDE_W-1:0] r_s6_numd;
    logic [MID_W-1:0]  r_s6_denh, r_s6_numa, r_s6_pc_lo, r_s6_pc_hi, r_s6_dend;
    logic [W-1:0]      r_s6_c0, r_s6_c1, r_s6_d0, r_s6_abs;
    logic [W:0]        r_s6_ws;
    logic              r_s6_second;

    always_ff @(posedge i_clk) begin
        r_s6_numd   <= (WIDE_W'(r_s5_nd_hi) << W) + WIDE_W'(r_s5_nd_lo);
        r_s6_denh   <= MID_W'(r_s5_hc) + MID_W'(r_s5_hd);
        r_s6_numa   <= MID_W'(r_s5_ac) + MID_W'(r_s5_ad);
        r_s6_pc_lo  <= MID_W'(r_s5_pc[W-1:0]) * MID_W'(r_s5_ws);
        r_s6_pc_hi  <= MID_W'(r_s5_pc[P_W-1:W]) * MID_W'(r_s5_ws);
        r_s6_dend   <= r_s5_dend;
        r_s6_c0     <= r_s5_c0;
        r_s6_c1     <= r_s5_c1;
        r_s6_d0     <= r_s5_d0;
        r_s6_abs    <= r_s5_abs;
        r_s6_ws     <= r_s5_ws;
        r_s6_second <= r_s5_second;
    end

    // ------------------------------------------------------------------
    // Stage 7: harmonic mean numerator of the coefficients.
    // ------------------------------------------------------------------
    logic              r_s7_valid;
    logic [WIDE_W-1:0] r_s7_numh, r_s7_numd;
    logic [MID_W-1:0]  r_s7_denh, r_s7_numa, r_s7_dend;
    logic [W-1:0]      r_s7_c0, r_s7_c1, r_s7_d0, r_s7_abs;
    logic [W:0]        r_s7_ws;
    logic              r_s7_second;

    always_ff @(posedge i_clk) begin
        r_s7_numh   <= (WIDE_W'(r_s6_pc_hi) << W) + WIDE_W'(r_s6_pc_lo);
        r_s7_numd   <= r_s6_numd;
        r_s7_denh   <= r_s6_denh;
        r_s7_numa   <= r_s6_numa;
        r_s7_dend   <= r_s6_dend;
        r_s7_c0     <= r_s6_c0;
        r_s7_c1     <= r_s6_c1;
        r_s7_d0     <= r_s6_d0;
        r_s7_abs    <= r_s6_abs;
        r_s7_ws     <= r_s6_ws;
        r_s7_second <= r_s6_second;
    end

    // Mean selection and zero divisor detection. When the downwind
    // coefficient is larger the harmonic mean is used (zero if the upwind
    // one is zero); a flux at or above the threshold takes the arithmetic
    // mean; anything else is a blend of the two.
    t_mean_side w_mean_side;
    logic       w_mean_err;
    logic       w_c0_zero, w_c1_zero, w_denh_zero, w_ws_zero, w_dend_zero;

    assign w_c0_zero   = (r_s7_c0 == '0);
    assign w_c1_zero   = (r_s7_c1 == '0);
    assign w_denh_zero = (r_s7_denh == '0);
    assign w_ws_zero   = (r_s7_ws == '0);
    assign w_dend_zero = (r_s7_dend == '0);

    always_comb begin
        w_mean_side.abs_flux = r_s7_abs;
        if (r_s7_c1 > r_s7_c0) begin
            w_mean_side.sel     = SEL_HARMONIC;
            w_mean_side.hm_keep = !w_c0_zero;
            w_mean_err          = !w_c0_zero && w_denh_zero;
        end else if (r_s7_abs >= r_flux_threshold) begin
            w_mean_side.sel     = SEL_ARITH;
            w_mean_side.hm_keep = 1'b0;
            w_mean_err          = w_ws_zero;
        end else begin
            w_mean_side.sel     = SEL_BLEND;
            w_mean_side.hm_keep = !w_c0_zero && !w_c1_zero;
            w_mean_err          = w_ws_zero ||
                                  (!w_c0_zero && !w_c1_zero && w_denh_zero);
        end
        // The combined denominator mean exists only on interior faces.
        if (r_s7_second && w_dend_zero) begin
            w_mean_err = 1'b1;
        end
    end

    t_denom_side w_denom_side_in;
    assign w_denom_side_in.second      = r_s7_second;
    assign w_denom_side_in.denom_first = r_s7_d0;

    // ------------------------------------------------------------------
    // Three dividers in parallel: harmonic mean and arithmetic mean of
    // the scaled coefficients, and harmonic mean of the denominators.
    // ------------------------------------------------------------------
    logic        w_hm_valid, w_am_valid, w_dm_valid;
    logic [W-1:0] w_hm_q, w_am_q, w_dm_q;
    t_mean_side  w_hm_side;
    logic        w_am_err;
    t_denom_side w_dm_side;

    ufc_div_pipe #(
        .NUM_W  (WIDE_W),
        .DEN_W  (MID_W),
        .QUO_W  (W),
        .SIDE_W ($bits(t_mean_side))
    ) u_div_hmean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s7_valid),
        .i_num   (r_s7_numh),
        .i_den   (r_s7_denh),
        .i_side  (w_mean_side),
        .o_valid (w_hm_valid),
        .o_quo   (w_hm_q),
        .o_side  (w_hm_side)
    );

    ufc_div_pipe #(
        .NUM_W  (MID_W),
        .DEN_W  (W + 1),
        .QUO_W  (W),
        .SIDE_W (1)
    ) u_div_amean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s7_valid),
        .i_num   (r_s7_numa),
        .i_den   (r_s7_ws),
        .i_side  (w_mean_err),
        .o_valid (w_am_valid),
        .o_quo   (w_am_q),
        .o_side  (w_am_err)
    );

    ufc_div_pipe #(
        .NUM_W  (WIDE_W),
        .DEN_W  (MID_W),
        .QUO_W  (W),
        .SIDE_W ($bits(t_denom_side))
    ) u_div_denom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s7_valid),
        .i_num   (r_s7_numd),
        .i_den   (r_s7_dend),
        .i_side  (w_denom_side_in),
        .o_valid (w_dm_valid),
        .o_quo   (w_dm_q),
        .o_side  (w_dm_side)
    );

    // ------------------------------------------------------------------
    // Stage 8: pick the harmonic mean (or zero), the gap to the arithmetic
    // mean, and the face denominator.
    // ------------------------------------------------------------------
    logic         r_s8_valid;
    logic [W-1:0] r_s8_hm, r_s8_am, r_s8_diff, r_s8_denom, r_s8_abs;
    t_mean_sel    r_s8_sel;
    logic         r_s8_err;
    logic [W-1:0] w_hm_val;

    assign w_hm_val = w_hm_side.hm_keep ? w_hm_q : '0;

    always_ff @(posedge i_clk) begin
        r_s8_hm    <= w_hm_val;
        r_s8_am    <= w_am_q;
        r_s8_diff  <= (w_am_q > w_hm_val) ? (w_am_q - w_hm_val) : '0;
        r_s8_denom <= w_dm_side.second ? w_dm_q : w_dm_side.denom_first;
        r_s8_abs   <= w_hm_side.abs_flux;
        r_s8_sel   <= w_hm_side.sel;
        r_s8_err   <= w_am_err;
    end

    // ------------------------------------------------------------------
    // Stage 9: blend product, then division by the flux threshold. The
    // blend is only used when the flux is below a nonzero threshold, so
    // the quotient always fits in 32 bits.
    // ------------------------------------------------------------------
    logic           r_s9_valid;
    logic [P_W-1:0] r_s9_prod;
    t_blend_side    r_s9_side;

    always_ff @(posedge i_clk) begin
        r_s9_prod       <= P_W'(r_s8_abs) * P_W'(r_s8_diff);
        r_s9_side.sel   <= r_s8_sel;
        r_s9_side.err   <= r_s8_err;
        r_s9_side.hm    <= r_s8_hm;
        r_s9_side.am    <= r_s8_am;
        r_s9_side.denom <= r_s8_denom;
    end

    logic        w_bl_valid;
    logic [W-1:0] w_bl_q;
    t_blend_side w_bl_side;

    ufc_div_pipe #(
        .NUM_W  (P_W),
        .DEN_W  (W),
        .QUO_W  (W),
        .SIDE_W ($bits(t_blend_side))
    ) u_div_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s9_valid),
        .i_num   (r_s9_prod),
        .i_den   (r_flux_threshold),
        .i_side  (r_s9_side),
        .o_valid (w_bl_valid),
        .o_quo   (w_bl_q),
        .o_side  (w_bl_side)
    );

    // ------------------------------------------------------------------
    // Stage 10: face value, and a zero face denominator joins the error.
    // ------------------------------------------------------------------
    logic         r_s10_valid;
    logic [W-1:0] r_s10_val, r_s10_denom;
    logic         r_s10_err;
    logic [W-1:0] n_s10_val;

    always_comb begin
        case (w_bl_side.sel)
            SEL_HARMONIC: n_s10_val = w_bl_side.hm;
            SEL_ARITH:    n_s10_val = w_bl_side.am;
            SEL_BLEND:    n_s10_val = w_bl_side.hm + w_bl_q;
            default:      n_s10_val = w_bl_side.am;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s10_val   <= n_s10_val;
        r_s10_denom <= w_bl_side.denom;
        r_s10_err   <= w_bl_side.err || (w_bl_side.denom == '0);
    end

    // Final normalization: (value << FRAC_BITS) / denominator, saturated.
    logic         w_fin_valid;
    logic [W-1:0] w_fin_q;
    logic         w_fin_err;

    ufc_div_pipe #(
        .NUM_W  (SQ_W),
        .DEN_W  (W),
        .QUO_W  (W),
        .SIDE_W (1)
    ) u_div_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s10_valid),
        .i_num   ({r_s10_val, {FRAC_BITS{1'b0}}}),
        .i_den   (r_s10_denom),
        .i_side  (r_s10_err),
        .o_valid (w_fin_valid),
        .o_quo   (w_fin_q),
        .o_side  (w_fin_err)
    );

    // ------------------------------------------------------------------
    // Output register. Any zero divisor forces the saturated value.
    // ------------------------------------------------------------------
    logic         r_out_valid;
    logic [W-1:0] r_out_coef;
    logic         r_out_err;

    always_ff @(posedge i_clk) begin
        r_out_coef <= w_fin_err ? '1 : w_fin_q;
        r_out_err  <= w_fin_err;
    end

    // Valid bits of the fixed stages; the units carry their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_s9_valid  <= 1'b0;
            r_s10_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= w_sqf_valid && w_sqs_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= w_hm_valid && w_am_valid && w_dm_valid;
            r_s9_valid  <= r_s8_valid;
            r_s10_valid <= w_bl_valid;
            r_out_valid <= w_fin_valid;
        end
    end

    assign o_strobe       = r_out_valid;
    assign o_face_coef    = r_out_coef;
    assign o_divide_error = r_out_err;

endmodule
`default_nettype wire

@@ rtl/ufc_sqrt_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_sqrt_pipe
// Pipelined integer square root, one root bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module ufc_sqrt_pipe #(
    parameter int X_W    = 48,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [X_W-1:0]            i_x,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [(X_W+1)/2-1:0]      o_root,
    output logic [SIDE_W-1:0]         o_side
);
    localparam int RT_W = (X_W + 1) / 2;
    localparam int PD_W = 2 * RT_W;

    logic [RT_W:0]     r_valid;
    logic [RT_W:0]     r_rem  [RT_W+1];
    logic [RT_W-1:0]   r_root [RT_W+1];
    logic [PD_W-1:0]   r_x    [RT_W+1];
    logic [SIDE_W-1:0] r_side [RT_W+1];

    logic [RT_W+2:0]   w_trial [RT_W];
    logic [RT_W+2:0]   w_sub   [RT_W];
    logic              w_fits  [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_step
        logic [RT_W+2:0] cur;
        assign cur        = {r_rem[k], r_x[k][PD_W-1:PD_W-2]};
        assign w_sub[k]   = {1'b0, r_root[k], 2'b01};
        assign w_fits[k]  = cur >= w_sub[k];
        assign w_trial[k] = w_fits[k] ? (cur - w_sub[k]) : cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[RT_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_x[0]    <= PD_W'(i_x);
        r_side[0] <= i_side;
        for (int k = 0; k < RT_W; k++) begin
            r_rem[k+1]  <= w_trial[k][RT_W:0];
            r_root[k+1] <= {r_root[k][RT_W-2:0], w_fits[k]};
            r_x[k+1]    <= {r_x[k][PD_W-3:0], 2'b00};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_valid[RT_W];
    assign o_root  = r_root[RT_W];
    assign o_side  = r_side[RT_W];

endmodule
`default_nettype wire

@@ rtl/ufc_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module ufc_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [QUO_W:0]    r_valid;
    logic [DEN_W-1:0]  r_rem  [QUO_W+1];
    logic [DEN_W-1:0]  r_den  [QUO_W+1];
    logic [QUO_W-1:0]  r_lq   [QUO_W+1];
    logic              r_sat  [QUO_W+1];
    logic [SIDE_W-1:0] r_side [QUO_W+1];

    logic [CMP_W-1:0]  w_high;
    logic [DEN_W:0]    w_next [QUO_W];
    logic              w_fits [QUO_W];

    // The quotient overflows (or the divisor is zero) when the part of the
    // numerator above the quotient bits is not below the divisor.
    assign w_high = CMP_W'(i_num >> QUO_W);

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] cur;
        assign cur       = {r_rem[k], r_lq[k][QUO_W-1]};
        assign w_fits[k] = cur >= {1'b0, r_den[k]};
        assign w_next[k] = w_fits[k] ? (cur - {1'b0, r_den[k]}) : cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[QUO_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DEN_W'(i_num >> QUO_W);
        r_den[0]  <= i_den;
        r_lq[0]   <= i_num[QUO_W-1:0];
        r_sat[0]  <= w_high >= CMP_W'(i_den);
        r_side[0] <= i_side;
        for (int k = 0; k < QUO_W; k++) begin
            r_rem[k+1]  <= w_next[k][DEN_W-1:0];
            r_den[k+1]  <= r_den[k];
            r_lq[k+1]   <= {r_lq[k][QUO_W-2:0], w_fits[k]};
            r_sat[k+1]  <= r_sat[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_quo   = r_sat[QUO_W] ? '1 : r_lq[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule
`default_nettype wire
